// File: rtl/core/btgdt_pkg.sv
// Shared types and constants for the binary to grouped decimal text converter.
`default_nettype none

package btgdt_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int BC_W        = 7;
    localparam int CH_W        = 6;

    // 1233/4096 approximates log10(2) closely enough for every width up to 64
    localparam int MAX_DIGITS  = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_W       = 4 * MAX_DIGITS;
    localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    localparam logic [CH_W-1:0] CH_ZERO  = 6'd48;
    localparam logic [CH_W-1:0] CH_SPACE = 6'd32;

    typedef struct packed {
        logic [63:0]     value;
        logic [BC_W-1:0] bit_count;
    } t_in_beat;

    typedef struct packed {
        logic [CH_W-1:0] character;
        logic            last;
    } t_out_beat;

endpackage

`default_nettype wire

// File: rtl/core/binary_to_grouped_decimal_text.sv
// Top level: binary value to grouped decimal ASCII text, one character per beat.
`default_nettype none

// One input beat carries an unsigned value and a bit count; the block answers with the
// decimal text of the low bit_count bits, most significant character first, a space
// between groups of three digits, no leading zeros, and last set on the final digit.
// A bit count of 0 produces no output beat; counts above VALUE_WIDTH saturate.
// Sequence: the input is taken only while the converter is idle. A shift-and-add-3
// double dabble loop shifts in all VALUE_WIDTH bits, the S_FIND state locates the leading
// digit, then one character leaves per cycle while the output is not stalled (at most 26).
// An empty item is dropped and the converter stays idle. The output register holds a
// finished character while the next item is already being converted.
module binary_to_grouped_decimal_text
    import btgdt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_beat  i_in,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_beat      o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_FIND,
        S_EMIT
    } t_state;

    t_state                 r_state,      n_state;
    logic [VALUE_WIDTH-1:0] r_bin,        n_bin;
    logic [BCD_W-1:0]       r_bcd,        n_bcd;
    logic [CNT_W-1:0]       r_cnt,        n_cnt;
    logic [DIG_IDX_W-1:0]   r_ptr,        n_ptr;
    logic [1:0]             r_grp,        n_grp;
    logic                   r_space_pend, n_space_pend;
    logic                   r_out_valid,  n_out_valid;
    t_out_beat              r_out,        n_out;

    logic                   w_accept;
    logic                   w_out_free;
    logic [BC_W-1:0]        w_nsat;
    logic [VALUE_WIDTH-1:0] w_masked;
    logic [BCD_W-1:0]       w_adj;
    logic [DIG_IDX_W-1:0]   w_lead;
    logic [1:0]             w_lead_grp;
    logic [3:0]             w_digit;

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_out      = r_out;
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        w_nsat = (i_in.bit_count > BC_W'(VALUE_WIDTH)) ? BC_W'(VALUE_WIDTH)
                                                       : i_in.bit_count;
        for (int i = 0; i < VALUE_WIDTH; i++) begin
            w_masked[i] = i_in.value[i] && (BC_W'(i) < w_nsat);
        end
    end

    // add-3 on every digit of 5 or more before the next shift
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            w_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                         : r_bcd[4*d +: 4];
        end
    end

    // highest nonzero digit, and its position within a group of three
    always_comb begin
        w_lead     = '0;
        w_lead_grp = 2'd0;
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] != 4'd0) begin
                w_lead     = DIG_IDX_W'(d);
                w_lead_grp = 2'(d % 3);
            end
        end
    end

    assign w_digit = r_bcd[{r_ptr, 2'b00} +: 4];

    always_comb begin
        n_state      = r_state;
        n_bin        = r_bin;
        n_bcd        = r_bcd;
        n_cnt        = r_cnt;
        n_ptr        = r_ptr;
        n_grp        = r_grp;
        n_space_pend = r_space_pend;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (w_nsat != '0)) begin
                    n_bin   = w_masked;
                    n_bcd   = '0;
                    n_cnt   = CNT_W'(VALUE_WIDTH - 1);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {w_adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                n_ptr        = w_lead;
                n_grp        = w_lead_grp;
                n_space_pend = 1'b0;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_space_pend) begin
                        n_out.character = CH_SPACE;
                        n_out.last      = 1'b0;
                        n_space_pend    = 1'b0;
                        n_ptr           = r_ptr - 1'b1;
                        n_grp           = 2'd2;
                    end else begin
                        n_out.character = CH_ZERO + {2'b00, w_digit};
                        n_out.last      = (r_ptr == '0);
                        if (r_ptr == '0) begin
                            n_state = S_IDLE;
                        end else if (r_grp == 2'd0) begin
                            n_space_pend = 1'b1;
                        end else begin
                            n_ptr = r_ptr - 1'b1;
                            n_grp = r_grp - 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_ptr <= n_ptr;
        r_grp <= n_grp;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_space_pend <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_space_pend <= n_space_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    // a group space never ends the text
    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.last) |-> (o_out.character != CH_SPACE))
        else $error("last beat carries a group space");

    // a space is always followed right away by a digit
    a_space_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && (o_out.character == CH_SPACE))
        |=> (o_valid && (o_out.character != CH_SPACE)))
        else $error("group space not followed by a digit");

    // a nonempty item starts the conversion loop
    a_accept_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_nsat != '0)) |=> (r_state == S_CONV))
        else $error("accepted item did not start conversion");

    // a space is only pending on a group boundary above the units digit
    a_space_pend_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_space_pend |-> ((r_state == S_EMIT) && (r_grp == 2'd0) && (r_ptr != '0)))
        else $error("group space pending off a group boundary");

endmodule

`default_nettype wire
